// ===== design/wtr_pkg.sv =====
// shared types and helpers for the weighted translation residual block
package wtr_pkg;

  localparam int unsigned RowW = 63;
  localparam int unsigned EntW = 21;
  localparam int unsigned IdxW = 3;
  localparam int unsigned FifoDepthDef = 4;

  typedef enum logic [IdxW-1:0] {
    REG_ROT0 = 3'd0,
    REG_ROT1 = 3'd1,
    REG_ROT2 = 3'd2,
    REG_TX   = 3'd3,
    REG_TY   = 3'd4,
    REG_TZ   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    logic        [30:0] cov_xx;
    logic        [30:0] cov_yy;
    logic        [30:0] cov_zz;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_xz;
    logic signed [31:0] cov_yz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] resid_u;
    logic signed [31:0] resid_v;
    logic        [30:0] weight_u;
    logic        [30:0] weight_v;
    logic signed [31:0] jac_u_tz;
    logic signed [31:0] jac_v_tz;
  } out_item_t;

  // per-axis quantities after the front end
  typedef struct packed {
    logic signed [31:0] dr0;
    logic signed [31:0] dr1;
    logic signed [31:0] dr2;
    logic signed [31:0] c;
    logic signed [31:0] t_a;
  } axis_t;

  typedef struct packed {
    axis_t              ax_u;
    axis_t              ax_v;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] cxx;
    logic signed [31:0] cyy;
    logic signed [31:0] czz;
    logic signed [31:0] cxy;
    logic signed [31:0] cxz;
    logic signed [31:0] cyz;
    logic signed [31:0] tz;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) return 32'sh7fffffff;
    if (x < -80'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ===== design/wtr_front.sv =====
// front end: config registers and row differences for both image axes
module wtr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  wtr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  output wtr_pkg::work_t      out_work_o
);
  import wtr_pkg::*;

  logic [RowW-1:0]    rot_q [3];
  logic signed [31:0] tr_q [3];
  logic               valid_q;
  work_t              work_q, work_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= 63'(64'd1 << 18);
      rot_q[1] <= 63'(64'd1 << 39);
      rot_q[2] <= 63'(64'd1 << 60);
      tr_q[0]  <= '0;
      tr_q[1]  <= '0;
      tr_q[2]  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROT0: rot_q[0] <= cfg_data_i[RowW-1:0];
        REG_ROT1: rot_q[1] <= cfg_data_i[RowW-1:0];
        REG_ROT2: rot_q[2] <= cfg_data_i[RowW-1:0];
        REG_TX:   tr_q[0]  <= cfg_data_i[31:0];
        REG_TY:   tr_q[1]  <= cfg_data_i[31:0];
        REG_TZ:   tr_q[2]  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] row_diff(input logic [RowW-1:0] ra,
      input logic [RowW-1:0] r2, input int k, input logic signed [31:0] c);
    logic signed [EntW-1:0] ea, e2;
    logic signed [63:0]     p;
    ea = ra[k*EntW +: EntW];
    e2 = r2[k*EntW +: EntW];
    p  = (64'(ea) <<< 16) - 64'(c) * 64'(e2);
    return sat32(80'(p >>> 18));
  endfunction

  function automatic axis_t mk_axis(input logic [RowW-1:0] ra, input logic [RowW-1:0] r2,
      input logic signed [31:0] c, input logic signed [31:0] t);
    axis_t a;
    a.dr0 = row_diff(ra, r2, 0, c);
    a.dr1 = row_diff(ra, r2, 1, c);
    a.dr2 = row_diff(ra, r2, 2, c);
    a.c   = c;
    a.t_a = t;
    return a;
  endfunction

  always_comb begin
    work_d.ax_u = mk_axis(rot_q[0], rot_q[2], in_item_i.image_u, tr_q[0]);
    work_d.ax_v = mk_axis(rot_q[1], rot_q[2], in_item_i.image_v, tr_q[1]);
    work_d.px   = in_item_i.point_x;
    work_d.py   = in_item_i.point_y;
    work_d.pz   = in_item_i.point_z;
    work_d.cxx  = {1'b0, in_item_i.cov_xx};
    work_d.cyy  = {1'b0, in_item_i.cov_yy};
    work_d.czz  = {1'b0, in_item_i.cov_zz};
    work_d.cxy  = in_item_i.cov_xy;
    work_d.cxz  = in_item_i.cov_xz;
    work_d.cyz  = in_item_i.cov_yz;
    work_d.tz   = tr_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) work_q <= work_d;
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;
endmodule

// ===== design/wtr_fifo.sv =====
// short queue between the front and back ends
module wtr_fifo #(
  parameter int unsigned Depth = wtr_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wtr_pkg::work_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output wtr_pkg::work_t data_o
);
  import wtr_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t         mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
endmodule

// ===== design/wtr_sqrt.sv =====
// pipelined floor square root, two result bits per stage
module wtr_sqrt (
  input  logic              clk_i,
  input  logic [61:0]       rad_i,
  output logic [30:0]       root_o
);
  localparam int unsigned Steps = 31;
  localparam int unsigned PerStg = 2;
  localparam int unsigned Stages = (Steps + PerStg - 1) / PerStg;

  logic [61:0]     rem_q  [Stages];
  logic [30:0]     root_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stg
    logic [61:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] rem_d;
    logic [30:0] root_d;
    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end
    always_comb begin
      logic [63:0] trial;
      int          b;
      rem_d  = rem_in;
      root_d = root_in;
      for (int k = 0; k < PerStg; k++) begin
        b = int'(Steps) - 1 - (s * int'(PerStg) + k);
        if (b >= 0) begin
          trial = ({33'd0, root_d} << (b + 1)) + (64'd1 << (2 * b));
          if ({2'b0, rem_d} >= trial) begin
            rem_d  = 62'({2'b0, rem_d} - trial);
            root_d = root_d | (31'd1 << b);
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
    end
  end

  assign root_o = root_q[Stages-1];
endmodule

// ===== design/wtr_back.sv =====
// back end: quadratic form, weight, residual and jacobian for both axes
module wtr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  wtr_pkg::work_t      work_i,
  output logic                valid_o,
  output wtr_pkg::out_item_t  item_o
);
  import wtr_pkg::*;

  localparam int unsigned SqLat = 16;

  typedef enum logic [1:0] {
    W_ZERO = 2'd0,
    W_MAX  = 2'd1,
    W_ROOT = 2'd2
  } wcls_e;

  function automatic logic signed [63:0] fmul(input logic signed [31:0] a,
      input logic signed [31:0] b);
    return (64'(a) * 64'(b)) >>> 16;
  endfunction

  // stage 1: C*dr products, dr*x products, c*tz
  typedef struct packed {
    logic signed [63:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [63:0] x0, x1, x2, ct;
  } s1_t;

  function automatic s1_t st1(input axis_t a, input work_t w);
    s1_t r;
    r.m00 = fmul(w.cxx, a.dr0); r.m01 = fmul(w.cxy, a.dr1); r.m02 = fmul(w.cxz, a.dr2);
    r.m10 = fmul(w.cxy, a.dr0); r.m11 = fmul(w.cyy, a.dr1); r.m12 = fmul(w.cyz, a.dr2);
    r.m20 = fmul(w.cxz, a.dr0); r.m21 = fmul(w.cyz, a.dr1); r.m22 = fmul(w.czz, a.dr2);
    r.x0  = fmul(a.dr0, w.px);  r.x1  = fmul(a.dr1, w.py);  r.x2  = fmul(a.dr2, w.pz);
    r.ct  = fmul(a.c, w.tz);
    return r;
  endfunction

  s1_t         s1u_q, s1v_q;
  axis_t       a1u_q, a1v_q;

  always_ff @(posedge clk_i) begin
    s1u_q <= st1(work_i.ax_u, work_i);
    s1v_q <= st1(work_i.ax_v, work_i);
    a1u_q <= work_i.ax_u;
    a1v_q <= work_i.ax_v;
  end

  // stage 2: sums
  typedef struct packed {
    logic signed [31:0] v0, v1, v2;
    logic signed [63:0] inner;
  } s2_t;

  function automatic s2_t st2(input s1_t s, input axis_t a);
    s2_t r;
    r.v0 = sat32(80'(s.m00) + 80'(s.m01) + 80'(s.m02));
    r.v1 = sat32(80'(s.m10) + 80'(s.m11) + 80'(s.m12));
    r.v2 = sat32(80'(s.m20) + 80'(s.m21) + 80'(s.m22));
    r.inner = 64'(a.t_a) - s.ct + s.x0 + s.x1 + s.x2;
    return r;
  endfunction

  s2_t   s2u_q, s2v_q;
  axis_t a2u_q, a2v_q;

  always_ff @(posedge clk_i) begin
    s2u_q <= st2(s1u_q, a1u_q);
    s2v_q <= st2(s1v_q, a1v_q);
    a2u_q <= a1u_q;
    a2v_q <= a1v_q;
  end

  // stage 3: dr*v products
  logic signed [63:0] q0u_q, q1u_q, q2u_q, q0v_q, q1v_q, q2v_q;
  logic signed [63:0] in3u_q, in3v_q;
  logic signed [31:0] c3u_q, c3v_q;

  always_ff @(posedge clk_i) begin
    q0u_q  <= fmul(a2u_q.dr0, s2u_q.v0);
    q1u_q  <= fmul(a2u_q.dr1, s2u_q.v1);
    q2u_q  <= fmul(a2u_q.dr2, s2u_q.v2);
    q0v_q  <= fmul(a2v_q.dr0, s2v_q.v0);
    q1v_q  <= fmul(a2v_q.dr1, s2v_q.v1);
    q2v_q  <= fmul(a2v_q.dr2, s2v_q.v2);
    in3u_q <= s2u_q.inner;
    in3v_q <= s2v_q.inner;
    c3u_q  <= a2u_q.c;
    c3v_q  <= a2v_q.c;
  end

  // stage 4: q and weight classification
  logic signed [65:0] qu, qv;
  wcls_e              clsu_d, clsv_d;
  logic [61:0]        radu_d, radv_d;

  always_comb begin
    qu = 66'(q0u_q) + 66'(q1u_q) + 66'(q2u_q);
    qv = 66'(q0v_q) + 66'(q1v_q) + 66'(q2v_q);
    clsu_d = (qu <= 0) ? W_ZERO : (qu >= (66'sd1 <<< 46)) ? W_MAX : W_ROOT;
    clsv_d = (qv <= 0) ? W_ZERO : (qv >= (66'sd1 <<< 46)) ? W_MAX : W_ROOT;
    radu_d = {qu[45:0], 16'd0};
    radv_d = {qv[45:0], 16'd0};
  end

  localparam int unsigned Dly = 17;
  typedef struct packed {
    wcls_e              clsu, clsv;
    logic signed [63:0] inu, inv;
    logic signed [31:0] cu, cv;
  } side_t;

  side_t side_q [Dly];
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{clsu: clsu_d, clsv: clsv_d, inu: in3u_q, inv: in3v_q,
                   cu: c3u_q, cv: c3v_q};
    for (int i = 1; i < Dly; i++) side_q[i] <= side_q[i-1];
  end

  logic [61:0] radu_q, radv_q;
  always_ff @(posedge clk_i) begin
    radu_q <= radu_d;
    radv_q <= radv_d;
  end

  logic [30:0] rootu, rootv;
  wtr_sqrt u_sqrt_u (.clk_i, .rad_i(radu_q), .root_o(rootu));
  wtr_sqrt u_sqrt_v (.clk_i, .rad_i(radv_q), .root_o(rootv));

  // weight select then residual multiply
  function automatic logic [30:0] pick(input wcls_e cls, input logic [30:0] r);
    unique case (cls)
      W_ZERO:  return '0;
      W_MAX:   return 31'h7fffffff;
      default: return r;
    endcase
  endfunction

  logic [30:0]        wu_q, wv_q;
  logic signed [63:0] inu_q, inv_q;
  logic signed [31:0] cu_q, cv_q;
  always_ff @(posedge clk_i) begin
    wu_q  <= pick(side_q[Dly-1].clsu, rootu);
    wv_q  <= pick(side_q[Dly-1].clsv, rootv);
    inu_q <= side_q[Dly-1].inu;
    inv_q <= side_q[Dly-1].inv;
    cu_q  <= side_q[Dly-1].cu;
    cv_q  <= side_q[Dly-1].cv;
  end

  // residual: split inner into high and low parts
  function automatic logic signed [79:0] wpart(input logic [30:0] w,
      input logic signed [63:0] inner, input logic hi);
    logic signed [39:0] part;
    part = hi ? 40'(inner >>> 24) : 40'({1'b0, inner[23:0]});
    return 80'($signed({1'b0, w})) * 80'(part);
  endfunction

  logic signed [79:0] phu_q, plu_q, phv_q, plv_q, jmu_q, jmv_q;
  logic [30:0]        wu5_q, wv5_q;
  always_ff @(posedge clk_i) begin
    phu_q <= wpart(wu_q, inu_q, 1'b1);
    plu_q <= wpart(wu_q, inu_q, 1'b0);
    phv_q <= wpart(wv_q, inv_q, 1'b1);
    plv_q <= wpart(wv_q, inv_q, 1'b0);
    jmu_q <= -(80'($signed({1'b0, wu_q})) * 80'(cu_q));
    jmv_q <= -(80'($signed({1'b0, wv_q})) * 80'(cv_q));
    wu5_q <= wu_q;
    wv5_q <= wv_q;
  end

  // high part is a multiple of 2^24, so only the low part needs the floor shift
  out_item_t res_q;
  always_ff @(posedge clk_i) begin
    res_q.resid_u  <= sat32((phu_q <<< 8) + (plu_q >>> 16));
    res_q.resid_v  <= sat32((phv_q <<< 8) + (plv_q >>> 16));
    res_q.weight_u <= wu5_q;
    res_q.weight_v <= wv5_q;
    res_q.jac_u_tz <= sat32(jmu_q >>> 16);
    res_q.jac_v_tz <= sat32(jmv_q >>> 16);
  end

  localparam int unsigned TotLat = 3 + 1 + SqLat + 1 + 1 + 1;
  logic [TotLat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[TotLat-2:0], valid_i};
  end

  assign valid_o = vld_q[TotLat-1];
  assign item_o  = res_q;
endmodule

// ===== design/weighted_translation_residual.sv =====
// top level of the weighted translation residual block
// usage:
//   configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high, write only while no beat is in flight
//   items: raise start with in_item_i; busy stays low, so a new point can be
//   given every cycle
//   results: done_o marks out_item_o for one cycle, in issue order
//   path: an item is registered in the front end and in the queue, then runs
//   through a 23-stage back end (three multiply/sum stages, a radicand
//   register, a 16-stage square root at two bits per stage, weight select,
//   split residual multiply, saturate)
//   throughput: one item per cycle
//   reset clears all valid flags and restores identity rotation, zero
//   translation; results cannot be stalled
module weighted_translation_residual #(
  parameter int unsigned FifoDepth = wtr_pkg::FifoDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  wtr_pkg::in_item_t  in_item_i,
  output logic               done_o,
  output wtr_pkg::out_item_t out_item_o
);
  import wtr_pkg::*;

  logic  fv;
  work_t fw, qw;
  logic  empty;

  assign busy = 1'b0;

  wtr_front u_front (.clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .in_valid_i(start & ~busy), .in_item_i, .out_valid_o(fv),
    .out_work_o(fw));

  wtr_fifo #(.Depth(FifoDepth)) u_fifo (.clk_i, .rst_ni, .push_i(fv), .data_i(fw),
    .pop_i(~empty), .empty_o(empty), .data_o(qw));

  wtr_back u_back (.clk_i, .rst_ni, .valid_i(~empty), .work_i(qw), .valid_o(done_o),
    .item_o(out_item_o));
endmodule

// ===== bench/weighted_translation_residual_tb.sv =====
// self-checking testbench for the weighted translation residual block
`timescale 1ns / 100ps

module weighted_translation_residual_tb;
  import wtr_pkg::*;

  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ItemsPerPhase = 290;

  typedef logic signed [127:0] wide_t;

  class residual_scoreboard;
    logic [62:0] rot_rows [3];
    wide_t trans [3];
    out_item_t pending [$];
    int unsigned errors;

    function new();
      rot_rows[0] = 63'd1 << 18;
      rot_rows[1] = 63'd1 << 39;
      rot_rows[2] = 63'd1 << 60;
      for (int k = 0; k < 3; k++) trans[k] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_ROT0: rot_rows[0] = data[62:0];
        REG_ROT1: rot_rows[1] = data[62:0];
        REG_ROT2: rot_rows[2] = data[62:0];
        REG_TX:   trans[0] = $signed(data[31:0]);
        REG_TY:   trans[1] = $signed(data[31:0]);
        REG_TZ:   trans[2] = $signed(data[31:0]);
        default: ;
      endcase
    endfunction

    static function wide_t clamp32(wide_t x);
      if (x > 128'sd2147483647) return 128'sd2147483647;
      if (x < -128'sd2147483648) return -128'sd2147483648;
      return x;
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else res >>= 1;
        bitv >>= 2;
      end
      return res;
    endfunction

    function wide_t rot_entry(int row, int col);
      logic signed [20:0] e;
      e = rot_rows[row][21*col +: 21];
      return e;
    endfunction

    function void axis_calc(int row, wide_t c, wide_t pt [3], wide_t cm [3][3],
                            output wide_t res, output wide_t wt, output wide_t jac);
      wide_t dr [3];
      wide_t vv [3];
      wide_t q, inner, w, s;
      for (int i = 0; i < 3; i++)
        dr[i] = clamp32((rot_entry(row, i) * 65536 - c * rot_entry(2, i)) >>> 18);
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += (cm[i][j] * dr[j]) >>> 16;
        vv[i] = clamp32(s);
      end
      q = 0;
      for (int i = 0; i < 3; i++) q += (dr[i] * vv[i]) >>> 16;
      if (q <= 0) w = 0;
      else if (q >= (128'sd1 <<< 46)) w = 128'sd2147483647;
      else w = floor_sqrt(64'(q) << 16);
      inner = trans[row] - ((c * trans[2]) >>> 16);
      for (int i = 0; i < 3; i++) inner += (dr[i] * pt[i]) >>> 16;
      res = clamp32((w * inner) >>> 16);
      wt = w;
      jac = clamp32((-(w * c)) >>> 16);
    endfunction

    function void note_item(in_item_t it);
      wide_t pt [3];
      wide_t cm [3][3];
      wide_t r0, r1, w0, w1, j0, j1;
      out_item_t exp_item;
      pt[0] = it.point_x;
      pt[1] = it.point_y;
      pt[2] = it.point_z;
      cm[0][0] = {97'd0, it.cov_xx};
      cm[1][1] = {97'd0, it.cov_yy};
      cm[2][2] = {97'd0, it.cov_zz};
      cm[0][1] = it.cov_xy;
      cm[1][0] = it.cov_xy;
      cm[0][2] = it.cov_xz;
      cm[2][0] = it.cov_xz;
      cm[1][2] = it.cov_yz;
      cm[2][1] = it.cov_yz;
      axis_calc(0, wide_t'(it.image_u), pt, cm, r0, w0, j0);
      axis_calc(1, wide_t'(it.image_v), pt, cm, r1, w1, j1);
      exp_item.resid_u = r0[31:0];
      exp_item.resid_v = r1[31:0];
      exp_item.weight_u = w0[30:0];
      exp_item.weight_v = w1[30:0];
      exp_item.jac_u_tz = j0[31:0];
      exp_item.jac_v_tz = j1[31:0];
      pending.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.resid_u !== e.resid_u) begin
        $display("%0t: resid_u exp %h act %h", $time, e.resid_u, got.resid_u);
        errors++;
      end
      if (got.resid_v !== e.resid_v) begin
        $display("%0t: resid_v exp %h act %h", $time, e.resid_v, got.resid_v);
        errors++;
      end
      if (got.weight_u !== e.weight_u) begin
        $display("%0t: weight_u exp %h act %h", $time, e.weight_u, got.weight_u);
        errors++;
      end
      if (got.weight_v !== e.weight_v) begin
        $display("%0t: weight_v exp %h act %h", $time, e.weight_v, got.weight_v);
        errors++;
      end
      if (got.jac_u_tz !== e.jac_u_tz) begin
        $display("%0t: jac_u_tz exp %h act %h", $time, e.jac_u_tz, got.jac_u_tz);
        errors++;
      end
      if (got.jac_v_tz !== e.jac_v_tz) begin
        $display("%0t: jac_v_tz exp %h act %h", $time, e.jac_v_tz, got.jac_v_tz);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        start;
  logic        busy;
  in_item_t    in_item_i;
  logic        done_o;
  out_item_t   out_item_o;

  residual_scoreboard sb;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  weighted_translation_residual uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy), .in_item_i(in_item_i),
    .done_o(done_o), .out_item_o(out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (start && !busy) sb.note_item(in_item_i);
      if (done_o) sb.check_result(out_item_o);
      if (quiet_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // signed value of modest magnitude in Q16.16
  function automatic logic [31:0] rnd_near(int unsigned mag);
    int v;
    v = $urandom_range(2 * mag) - mag;
    return v;
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    if ($urandom_range(99) < 30) begin
      it = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), 31'(rnd32()),
            31'(rnd32()), 31'(rnd32()), rnd32(), rnd32(), rnd32()};
    end else begin
      it.point_x = rnd_near(32'h0040_0000);
      it.point_y = rnd_near(32'h0040_0000);
      it.point_z = rnd_near(32'h0040_0000);
      it.image_u = rnd_near(32'h0002_0000);
      it.image_v = rnd_near(32'h0002_0000);
      it.cov_xx = 31'($urandom_range(32'h0004_0000));
      it.cov_yy = 31'($urandom_range(32'h0004_0000));
      it.cov_zz = 31'($urandom_range(32'h0004_0000));
      it.cov_xy = rnd_near(32'h0000_8000);
      it.cov_xz = rnd_near(32'h0000_8000);
      it.cov_yz = rnd_near(32'h0000_8000);
    end
    return it;
  endfunction

  function automatic logic [63:0] rnd_rot_row();
    logic [20:0] e [3];
    if ($urandom_range(99) < 30) return {rnd32(), rnd32()};
    for (int k = 0; k < 3; k++) e[k] = 21'(rnd_near(32'h0004_0000));
    return {1'b0, e[2], e[1], e[0]};
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    in_item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    write_reg(REG_ROT0, r0);
    write_reg(REG_ROT1, r1);
    write_reg(REG_ROT2, r2);
    write_reg(REG_TX, {rnd32(), tx});
    write_reg(REG_TY, {rnd32(), ty});
    write_reg(REG_TZ, {rnd32(), tz});
  endtask

  task automatic directed_items();
    in_item_t it;
    it = '0;
    send_item(it);
    it = '1;
    send_item(it);
    it = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff};
    send_item(it);
    it = {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000};
    send_item(it);
    // covariance that is not positive semidefinite
    it = {32'h00010000, 32'h00020000, 32'h00030000, 32'h00004000, 32'hffffc000,
          31'd0, 31'd0, 31'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_item(it);
    // weight beyond range
    it = {32'h00010000, 32'h00010000, 32'h00010000, 32'h7fffffff, 32'h80000000,
          31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'd0, 32'd0, 32'd0};
    send_item(it);
    // unit covariance, small point
    it = {32'h00010000, 32'hffff0000, 32'h00050000, 32'h00008000, 32'hffff8000,
          31'h00010000, 31'h00010000, 31'h00010000, 32'd0, 32'd0, 32'd0};
    send_item(it);
    it = {32'h00000001, 32'hffffffff, 32'h00000001, 32'h00000001, 32'hffffffff,
          31'd1, 31'd1, 31'd1, 32'hffffffff, 32'd1, 32'hffffffff};
    send_item(it);
    for (int k = 0; k < 6; k++) send_item(rnd_item());
  endtask

  initial begin
    sb = new();
    quiet_cycles = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ROT0;
    cfg_data_i = '0;
    start = 1'b0;
    in_item_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: write_all(64'hffffffffffffffff, 64'h7fffffffffffffff, '0,
                     32'h7fffffff, 32'h80000000, 32'h7fffffff);
        1: write_all({1'b1, 63'(64'd1 << 18)}, 64'd1 << 39, 64'd1 << 60,
                     32'h00010000, 32'hffff0000, 32'h00020000);
        2: write_all('0, '0, 64'hffffffffffffffff, 32'h80000000, 32'h80000000,
                     32'h80000000);
        default: write_all(rnd_rot_row(), rnd_rot_row(), rnd_rot_row(),
                           rnd_near(32'h0010_0000), rnd_near(32'h0010_0000),
                           rnd_near(32'h0010_0000));
      endcase
      write_reg(REG_SPARE6, {rnd32(), rnd32()});
      write_reg(REG_SPARE7, {rnd32(), rnd32()});
      idle_pct = (phase < 2) ? 15 : (phase < 4) ? 81 : 0;
      if (phase == 1) directed_items();
      for (int n = 0; n < ItemsPerPhase; n++) send_item(rnd_item());
    end
    wait_idle();

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
design/wtr_pkg.sv
design/wtr_front.sv
design/wtr_fifo.sv
design/wtr_sqrt.sv
design/wtr_back.sv
design/weighted_translation_residual.sv
bench/weighted_translation_residual_tb.sv
